@@ hdl/drfp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the display reply frame parser.
// No dependencies; every other file of the block imports this package.
package drfp_pkg;

   // Default size of the receive buffer in bytes.
   localparam int RX_BUF_BYTES_DEF = 68;

   localparam logic [7:0] HDR_TOUCH  = 8'h65;
   localparam logic [7:0] HDR_TEXT   = 8'h70;
   localparam logic [7:0] HDR_NUMBER = 8'h71;
   localparam logic [7:0] TERM_BYTE  = 8'hFF;

   // Frame lengths (bytes before the terminator) that the fixed-size replies need.
   localparam int TOUCH_LEN  = 4;
   localparam int NUMBER_LEN = 5;

   // Configuration register indexes.
   localparam logic CSR_PRESS_CODE   = 1'b0;
   localparam logic CSR_RELEASE_CODE = 1'b1;

   typedef enum logic [1:0] {
      KIND_TOUCH  = 2'd0,
      KIND_NUMBER = 2'd1,
      KIND_TEXT   = 2'd2,
      KIND_EMPTY  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_TOUCH,
      MODE_NUMBER,
      MODE_TEXT,
      MODE_EMPTY
   } frame_mode_type;

   typedef enum logic [1:0] {
      DEC_IDLE,
      DEC_CAP,
      DEC_FIN
   } dec_state_type;

   // Handed from the receive front end to the decode sequencer on a terminator.
   typedef struct packed {
      logic           valid;
      frame_mode_type mode;
   } frame_start_type;

   // One result beat.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  page;
      logic [7:0]  object_id;
      logic        pressed;
      logic [31:0] value;
      logic [7:0]  text_byte;
      logic        last;
   } rsp_item_type;

endpackage

@@ hdl/display_reply_frame_parser.sv @@
`timescale 1ns / 1ps
// Top level of the display reply frame parser.
// Depends on drfp_pkg, drfp_frame_ram, drfp_rx_front and drfp_decode_seq.
//
// Usage: received link bytes enter one beat at a time on the req_ channel, each
// with req_burst_end set on the last byte of a receive burst. Within a burst the
// bytes are written to a frame buffer until three 0xFF bytes in a row are seen;
// the frame is then read back from the buffer and decoded into result beats on
// the rsp_ channel (touch event, 32-bit number, a run of text bytes with rsp_last
// on the final one, or a single empty-text beat).
// Throughput: one byte per cycle is accepted while no frame is being decoded.
// After the terminator of a recognized reply is accepted, req_ready stays low
// while the decode sequencer reads the frame back through the buffer's single
// read port and loads its beats; text bytes are read back one per cycle while
// the receiver does not stall. The final beat sits in an output register, so
// input resumes as soon as the last beat has been loaded there.
// Stalls: when rsp_ready is low the output register holds its beat and the
// sequencer waits; the buffer read data holds, so nothing is lost.
// Reset clears the burst state, the sequencer and the output valid, and sets
// press code 1 and release code 0. The buffer itself needs no clearing pass.
// Configuration: csr_we writes csr_wdata to the register csr_index.
module display_reply_frame_parser #(
   parameter int RX_BUF_BYTES = drfp_pkg::RX_BUF_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_burst_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_page,
   output logic [7:0]  rsp_object_id,
   output logic        rsp_pressed,
   output logic [31:0] rsp_value,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import drfp_pkg::*;

   localparam int AW = $clog2(RX_BUF_BYTES);

   logic [7:0]      press_ff, press_in;
   logic [7:0]      release_ff, release_in;
   logic            beat_take;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [7:0]      wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [7:0]      rd_data;
   frame_start_type start;
   logic [AW-1:0]   end_idx;
   logic            dec_idle;
   rsp_item_type    rsp_item;

   // Configuration registers.
   always_comb begin
      press_in   = press_ff;
      release_in = release_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PRESS_CODE:   press_in   = csr_wdata;
            CSR_RELEASE_CODE: release_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff   <= 8'd1;
         release_ff <= 8'd0;
      end else begin
         press_ff   <= press_in;
         release_ff <= release_in;
      end
   end

   // Holding input off while decoding keeps the next burst from overwriting
   // buffer entries that the sequencer still has to read.
   assign req_ready = dec_idle;
   assign beat_take = req_valid && req_ready;

   drfp_rx_front #(.RX_BUF_BYTES(RX_BUF_BYTES)) u_rx_front (
      .clock     (clock),
      .reset     (reset),
      .beat_take (beat_take),
      .rx_byte   (req_rx_byte),
      .burst_end (req_burst_end),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .start     (start),
      .end_idx   (end_idx)
   );

   drfp_frame_ram #(.RX_BUF_BYTES(RX_BUF_BYTES)) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   drfp_decode_seq #(.RX_BUF_BYTES(RX_BUF_BYTES)) u_decode_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .end_idx      (end_idx),
      .press_code   (press_ff),
      .release_code (release_ff),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .idle         (dec_idle),
      .rsp_item     (rsp_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready)
   );

   assign rsp_kind      = rsp_item.kind;
   assign rsp_page      = rsp_item.page;
   assign rsp_object_id = rsp_item.object_id;
   assign rsp_pressed   = rsp_item.pressed;
   assign rsp_value     = rsp_item.value;
   assign rsp_text_byte = rsp_item.text_byte;
   assign rsp_last      = rsp_item.last;

endmodule

@@ hdl/drfp_frame_ram.sv @@
`timescale 1ns / 1ps
// Frame buffer: one write port, one read port with registered read data.
// Depends on drfp_pkg for the default depth.
module drfp_frame_ram #(
   parameter int RX_BUF_BYTES = drfp_pkg::RX_BUF_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(RX_BUF_BYTES)-1:0] wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(RX_BUF_BYTES)-1:0] rd_addr,
   output logic [7:0]                      rd_data
);
   import drfp_pkg::*;

   logic [7:0] frame_mem [RX_BUF_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/drfp_rx_front.sv @@
`timescale 1ns / 1ps
// Receive front end: stores burst bytes in the frame buffer, finds the terminator
// and classifies the frame. Depends on drfp_pkg.
module drfp_rx_front #(
   parameter int RX_BUF_BYTES = drfp_pkg::RX_BUF_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              beat_take,
   input  logic [7:0]                        rx_byte,
   input  logic                              burst_end,
   output logic                              wr_en,
   output logic [$clog2(RX_BUF_BYTES)-1:0]   wr_addr,
   output logic [7:0]                        wr_data,
   output drfp_pkg::frame_start_type         start,
   output logic [$clog2(RX_BUF_BYTES)-1:0]   end_idx
);
   import drfp_pkg::*;

   localparam int AW = $clog2(RX_BUF_BYTES);
   localparam int CW = $clog2(RX_BUF_BYTES + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    ff_run_ff, ff_run_in;
   logic          done_ff, done_in;
   logic [7:0]    header_ff, header_in;
   logic          store;
   logic          terminate;
   logic [CW-1:0] frame_len;

   assign store     = beat_take && !done_ff && (count_ff < CW'(RX_BUF_BYTES));
   assign terminate = store && (rx_byte == TERM_BYTE) && (ff_run_ff == 2'd2);
   // Bytes before the terminator: the stored count after this byte, less three.
   assign frame_len = count_ff - CW'(2);

   assign wr_en   = store;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = rx_byte;
   assign end_idx = AW'(frame_len - CW'(1));

   always_comb begin
      start.valid = 1'b0;
      start.mode  = MODE_TEXT;
      if (terminate && frame_len != '0) begin
         priority if (header_ff == HDR_TOUCH && frame_len == CW'(TOUCH_LEN)) begin
            start.valid = 1'b1;
            start.mode  = MODE_TOUCH;
         end else if (header_ff == HDR_NUMBER && frame_len == CW'(NUMBER_LEN)) begin
            start.valid = 1'b1;
            start.mode  = MODE_NUMBER;
         end else if (header_ff == HDR_TEXT) begin
            start.valid = 1'b1;
            start.mode  = (frame_len == CW'(1)) ? MODE_EMPTY : MODE_TEXT;
         end else begin
            start.valid = 1'b0;
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      ff_run_in = ff_run_ff;
      done_in   = done_ff;
      header_in = header_ff;
      if (store) begin
         count_in = count_ff + CW'(1);
         if (count_ff == '0) begin
            header_in = rx_byte;
         end
         if (rx_byte == TERM_BYTE) begin
            if (terminate) begin
               done_in   = 1'b1;
               ff_run_in = 2'd0;
            end else begin
               ff_run_in = ff_run_ff + 2'd1;
            end
         end else begin
            ff_run_in = 2'd0;
         end
      end
      if (beat_take && burst_end) begin
         count_in  = '0;
         ff_run_in = 2'd0;
         done_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ff_run_ff <= 2'd0;
         done_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ff_run_ff <= ff_run_in;
         done_ff   <= done_in;
      end
      header_ff <= header_in;
   end

endmodule

@@ hdl/drfp_decode_seq.sv @@
`timescale 1ns / 1ps
// Decode sequencer: reads a finished frame back from the frame buffer and
// builds result beats in the output register. Depends on drfp_pkg.
module drfp_decode_seq #(
   parameter int RX_BUF_BYTES = drfp_pkg::RX_BUF_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  drfp_pkg::frame_start_type         start,
   input  logic [$clog2(RX_BUF_BYTES)-1:0]   end_idx,
   input  logic [7:0]                        press_code,
   input  logic [7:0]                        release_code,
   output logic                              rd_en,
   output logic [$clog2(RX_BUF_BYTES)-1:0]   rd_addr,
   input  logic [7:0]                        rd_data,
   output logic                              idle,
   output drfp_pkg::rsp_item_type            rsp_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready
);
   import drfp_pkg::*;

   localparam int AW = $clog2(RX_BUF_BYTES);

   dec_state_type  state_ff, state_in;
   frame_mode_type mode_ff, mode_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  end_ff, end_in;
   logic [31:0]    acc_ff, acc_in;
   rsp_item_type   rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           at_end;
   logic [7:0]     event_byte;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign at_end     = (idx_ff == end_ff);
   assign event_byte = acc_ff[31:24];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DEC_IDLE: begin
            if (start.valid) begin
               state_in = (start.mode == MODE_EMPTY) ? DEC_FIN : DEC_CAP;
            end
         end
         DEC_CAP: begin
            priority if (mode_ff == MODE_TEXT) begin
               if (out_free && at_end) begin
                  state_in = DEC_IDLE;
               end
            end else if (at_end) begin
               state_in = DEC_FIN;
            end else begin
               state_in = DEC_CAP;
            end
         end
         DEC_FIN: begin
            if (out_free) begin
               state_in = DEC_IDLE;
            end
         end
         default: state_in = DEC_IDLE;
      endcase
   end

   // Buffer reads, accumulation and result loading.
   always_comb begin
      rd_en        = 1'b0;
      rd_addr      = idx_ff + AW'(1);
      idx_in       = idx_ff;
      end_in       = end_ff;
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         DEC_IDLE: begin
            if (start.valid) begin
               mode_in = start.mode;
               end_in  = end_idx;
               idx_in  = AW'(1);
               if (start.mode != MODE_EMPTY) begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(1);
               end
            end
         end
         DEC_CAP: begin
            if (mode_ff == MODE_TEXT) begin
               if (out_free) begin
                  rsp_in           = '0;
                  rsp_in.kind      = KIND_TEXT;
                  rsp_in.text_byte = rd_data;
                  rsp_in.last      = at_end;
                  rsp_valid_in     = 1'b1;
                  if (!at_end) begin
                     rd_en  = 1'b1;
                     idx_in = idx_ff + AW'(1);
                  end
               end
            end else begin
               // Little-endian: each byte enters at the top and moves down.
               acc_in = {rd_data, acc_ff[31:8]};
               if (!at_end) begin
                  rd_en  = 1'b1;
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         DEC_FIN: begin
            if (out_free) begin
               rsp_in      = '0;
               rsp_in.last = 1'b1;
               unique case (mode_ff)
                  MODE_TOUCH: begin
                     // Three bytes shifted in: page, object id, event.
                     rsp_in.kind      = KIND_TOUCH;
                     rsp_in.page      = acc_ff[15:8];
                     rsp_in.object_id = acc_ff[23:16];
                     rsp_in.pressed   = (event_byte == press_code);
                     rsp_valid_in     = (event_byte == press_code) ||
                                        (event_byte == release_code);
                  end
                  MODE_NUMBER: begin
                     rsp_in.kind  = KIND_NUMBER;
                     rsp_in.value = acc_ff;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_EMPTY: begin
                     rsp_in.kind  = KIND_EMPTY;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_TEXT: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DEC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      idx_ff  <= idx_in;
      end_ff  <= end_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign idle      = (state_ff == DEC_IDLE);
   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start.valid |-> state_ff == DEC_IDLE)
      else $error("frame start while a frame is still being decoded");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == DEC_CAP |-> idx_ff <= end_ff)
      else $error("read index ran past the end of the frame");

   a_read_then_capture: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> state_ff == DEC_CAP)
      else $error("buffer read data arrived outside the capture state");

   a_only_text_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> rsp_ff.kind == KIND_TEXT)
      else $error("a non-final beat that is not a text byte");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the display reply frame parser.
// Depends on drfp_pkg and display_reply_frame_parser; a queue-fed driver and a
// checking monitor compare every result beat with an in-line frame decoder.
module testbench;
   import drfp_pkg::*;

   localparam int RX_BUF      = 68;
   // Covers the read-back of the longest text reply after its terminator, so
   // this also covers frames that end without any result beat.
   localparam int DRAIN_GAP   = 100;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BEATS = 72;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } rx_beat_type;

   // Clock, reset and the block's ports. Every input holds a known value from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_burst_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_page;
   logic [7:0]  rsp_object_id;
   logic        rsp_pressed;
   logic [31:0] rsp_value;
   logic [7:0]  rsp_text_byte;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_PRESS_CODE;
   logic [7:0]  csr_wdata = 8'h00;

   // Byte beats waiting to be driven, and result beats the decoder has predicted.
   rx_beat_type  pending_beats[$];
   rx_beat_type  next_beat;
   rsp_item_type replies_due[$];
   logic [7:0]   frame_body[$];
   int           beats_queued = 0;

   // The decoder's own copy of the registers and of the burst state.
   logic [7:0]  press_now = 8'd1;
   logic [7:0]  release_now = 8'd0;
   int          stored_cnt = 0;
   int          ff_seen = 0;
   bit          term_found = 1'b0;
   logic [7:0]  frame_buf[RX_BUF];

   // Percent of cycles in which the sender and the receiver hold back.
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        req_beat_done = 1'b0;
   int          mismatches = 0;
   int          cycle_count = 0;

   display_reply_frame_parser uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .req_burst_end (req_burst_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_page      (rsp_page),
      .rsp_object_id (rsp_object_id),
      .rsp_pressed   (rsp_pressed),
      .rsp_value     (rsp_value),
      .rsp_text_byte (rsp_text_byte),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decodes one complete frame of the given length from the stored bytes and
   // queues the result beats it should produce. The header is always byte zero.
   function automatic void decode_reply(int len);
      rsp_item_type r;
      int tl;
      r = '0;
      r.last = 1'b1;
      if (len == 0)
         return;
      case (frame_buf[0])
         HDR_TOUCH: begin
            // A touch reply counts only when its event byte matches a set code;
            // press wins when both codes are equal.
            if (len == TOUCH_LEN) begin
               r.kind = KIND_TOUCH;
               r.page = frame_buf[1];
               r.object_id = frame_buf[2];
               if (frame_buf[3] == press_now) begin
                  r.pressed = 1'b1;
                  replies_due.push_back(r);
               end else if (frame_buf[3] == release_now) begin
                  replies_due.push_back(r);
               end
            end
         end
         HDR_NUMBER: begin
            if (len == NUMBER_LEN) begin
               r.kind = KIND_NUMBER;
               r.value = {frame_buf[4], frame_buf[3], frame_buf[2], frame_buf[1]};
               replies_due.push_back(r);
            end
         end
         HDR_TEXT: begin
            tl = len - 1;
            if (tl == 0) begin
               r.kind = KIND_EMPTY;
               replies_due.push_back(r);
            end else begin
               for (int i = 0; i < tl && (1 + i) < RX_BUF && i < 64; i++) begin
                  r.kind = KIND_TEXT;
                  r.text_byte = frame_buf[1 + i];
                  r.last = (i + 1 == tl);
                  replies_due.push_back(r);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Follows one accepted byte through the burst state. Bytes after the
   // terminator and bytes beyond a full buffer are not stored and do not count
   // toward the 0xFF run; the burst end clears everything after the byte.
   function automatic void absorb_rx_byte(logic [7:0] b, logic burst_last);
      if (!term_found && stored_cnt < RX_BUF) begin
         frame_buf[stored_cnt] = b;
         stored_cnt++;
         if (b == TERM_BYTE) begin
            ff_seen++;
            if (ff_seen >= 3) begin
               term_found = 1'b1;
               ff_seen = 0;
               decode_reply(stored_cnt - 3);
            end
         end else begin
            ff_seen = 0;
         end
      end
      if (burst_last) begin
         stored_cnt = 0;
         ff_seen = 0;
         term_found = 1'b0;
      end
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endfunction

   // Monitor: every accepted byte beat feeds the decoder, and every accepted
   // result beat is checked against the oldest prediction. A beat cannot be
   // predicted and returned in the same cycle, but the decoder runs first anyway.
   always @(posedge clock) begin
      rsp_item_type want;
      req_beat_done <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready)
            absorb_rx_byte(req_rx_byte, req_burst_end);
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               $error("result beat with nothing expected: kind %0d", rsp_kind);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("page", want.page, rsp_page);
               check_field("object_id", want.object_id, rsp_object_id);
               check_field("pressed", want.pressed, rsp_pressed);
               check_field("value", want.value, rsp_value);
               check_field("text_byte", want.text_byte, rsp_text_byte);
               check_field("last", want.last, rsp_last);
            end
         end
      end
   end

   // Driver: a new beat is offered only when the line is empty or the last
   // beat was taken at the previous rising edge, so valid never drops early.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_done) begin
         if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_beat = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_rx_byte <= next_beat.data;
            req_burst_end <= next_beat.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiver stalls at random, independently of what it is being offered.
   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_beat(input logic [7:0] b, input logic fin);
      rx_beat_type beat;
      beat.data = b;
      beat.last = fin;
      pending_beats.push_back(beat);
      beats_queued++;
   endtask

   // Queues the body held in frame_body, then the three-byte terminator, then
   // a few trailing bytes that the block must ignore. With close set, the
   // burst ends on the last byte queued; otherwise it stays open.
   task automatic queue_frame(input int trail, input bit close);
      foreach (frame_body[i])
         push_beat(frame_body[i], 1'b0);
      push_beat(TERM_BYTE, 1'b0);
      push_beat(TERM_BYTE, 1'b0);
      push_beat(TERM_BYTE, close && trail == 0);
      for (int i = 0; i < trail; i++)
         push_beat(8'($urandom), close && i == trail - 1);
      frame_body.delete();
   endtask

   // Registers are only written with the block idle, so the decoder's copy
   // changes at the same point as the hardware's.
   task automatic write_csr(input logic idx, input logic [7:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PRESS_CODE)
         press_now = data;
      else
         release_now = data;
   endtask

   // Waits until all bytes are taken and all predicted results are back, then
   // lets a frame that produces nothing finish its read-back.
   task automatic drain_block();
      while (pending_beats.size() != 0 || req_valid || replies_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   // One random burst. Most bursts are well-formed replies with random content
   // so that the decoder is reached; the rest are wrong lengths, foreign
   // headers, noise with many 0xFF bytes, and bursts cut short.
   task automatic queue_random_burst();
      int roll;
      int n;
      int trail;
      bit close;
      logic [7:0] ev;
      roll = $urandom_range(0, 99);
      trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      close = ($urandom_range(0, 9) != 0);
      if (roll < 25) begin
         case ($urandom_range(0, 2))
            0: ev = press_now;
            1: ev = release_now;
            default: ev = 8'($urandom);
         endcase
         frame_body = {HDR_TOUCH, 8'($urandom), 8'($urandom), ev};
         queue_frame(trail, close);
      end else if (roll < 45) begin
         frame_body = {HDR_NUMBER, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
         queue_frame(trail, close);
      end else if (roll < 70) begin
         // Long text runs are rare; they cost many beats each.
         n = ($urandom_range(0, 24) == 0) ? $urandom_range(40, 64) : $urandom_range(0, 8);
         frame_body = {HDR_TEXT};
         repeat (n) frame_body.push_back(8'($urandom));
         queue_frame(trail, close);
      end else if (roll < 82) begin
         case ($urandom_range(0, 2))
            0: frame_body = {HDR_TOUCH};
            1: frame_body = {HDR_NUMBER};
            default: frame_body = {8'($urandom)};
         endcase
         n = $urandom_range(0, 6);
         repeat (n) frame_body.push_back(8'($urandom));
         queue_frame(trail, close);
      end else if (roll < 92) begin
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++)
            push_beat(($urandom_range(0, 9) < 4) ? TERM_BYTE : 8'($urandom),
                      $urandom_range(0, 7) == 0);
      end else begin
         // A reply whose burst ends before its terminator is complete.
         push_beat(($urandom_range(0, 1) == 0) ? HDR_TEXT : HDR_TOUCH, 1'b0);
         n = $urandom_range(0, 4);
         repeat (n) push_beat(8'($urandom), 1'b0);
         if ($urandom_range(0, 1) == 0)
            push_beat(TERM_BYTE, 1'b0);
         push_beat(8'($urandom_range(0, 254)), 1'b1);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset codes: press 1, release 0.
      send_idle_pct = 25;
      recv_idle_pct = 48;
      frame_body = {HDR_TOUCH, 8'h00, 8'h00, 8'h01};
      queue_frame(0, 1'b1);
      // Release, with bytes after the terminator that must be ignored.
      frame_body = {HDR_TOUCH, 8'hFF, 8'hFE, 8'h00};
      queue_frame(2, 1'b1);
      // Event byte that matches neither code.
      frame_body = {HDR_TOUCH, 8'h12, 8'h34, 8'h07};
      queue_frame(0, 1'b1);
      frame_body = {HDR_NUMBER, 8'h00, 8'h00, 8'h00, 8'h00};
      queue_frame(0, 1'b1);
      frame_body = {HDR_NUMBER, 8'hFF, 8'hFF, 8'h00, 8'h80};
      queue_frame(0, 1'b1);
      frame_body = {HDR_TEXT};
      queue_frame(0, 1'b1);
      frame_body = {HDR_TEXT, 8'h41, 8'h42};
      queue_frame(0, 1'b1);
      // Foreign header, then wrong lengths for touch and number.
      frame_body = {8'h42, 8'h01};
      queue_frame(0, 1'b1);
      frame_body = {HDR_TOUCH, 8'h01, 8'h02};
      queue_frame(0, 1'b1);
      frame_body = {HDR_NUMBER, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
      queue_frame(0, 1'b1);
      // A burst that opens with the terminator: length zero, header 0xFF.
      queue_frame(0, 1'b1);
      // Two 0xFF bytes broken by another byte, and no terminator at all.
      frame_body = {HDR_TEXT, 8'h41, TERM_BYTE, TERM_BYTE, 8'h42};
      foreach (frame_body[i])
         push_beat(frame_body[i], i == frame_body.size() - 1);
      frame_body.delete();
      // A second frame in the same burst is ignored after the first terminator.
      frame_body = {HDR_TEXT, 8'h43};
      queue_frame(0, 1'b0);
      frame_body = {HDR_TOUCH, 8'h00, 8'h00, 8'h01};
      queue_frame(0, 1'b1);
      // A burst that ends mid-frame leaves no state behind for the next one.
      push_beat(HDR_TOUCH, 1'b0);
      push_beat(8'h01, 1'b1);
      frame_body = {HDR_TEXT, 8'h44};
      queue_frame(0, 1'b1);
      // Full buffer: the terminator arrives after 68 stored bytes and is dropped.
      frame_body = {HDR_TEXT};
      repeat (RX_BUF - 1) frame_body.push_back(8'h55);
      queue_frame(0, 1'b1);
      // Longest text reply that still fits: 64 text beats.
      frame_body = {HDR_TEXT};
      repeat (64) frame_body.push_back(8'($urandom_range(0, 254)));
      queue_frame(0, 1'b1);
      drain_block();

      // Press code equal to release code: a match counts as press.
      write_csr(CSR_PRESS_CODE, 8'h80);
      write_csr(CSR_RELEASE_CODE, 8'h80);
      frame_body = {HDR_TOUCH, 8'h07, 8'h09, 8'h80};
      queue_frame(0, 1'b1);
      frame_body = {HDR_TOUCH, 8'h07, 8'h09, 8'h00};
      queue_frame(0, 1'b1);
      drain_block();

      // Random part in three phases, each with its own codes and idling.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_PRESS_CODE, 8'hFF);
               write_csr(CSR_RELEASE_CODE, 8'h00);
               send_idle_pct = 25;
               recv_idle_pct = 48;
            end
            1: begin
               write_csr(CSR_PRESS_CODE, 8'h00);
               write_csr(CSR_RELEASE_CODE, 8'hFF);
               send_idle_pct = 48;
               recv_idle_pct = 25;
            end
            default: begin
               write_csr(CSR_PRESS_CODE, 8'($urandom));
               write_csr(CSR_RELEASE_CODE, 8'($urandom));
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         beats_queued = 0;
         while (beats_queued < PHASE_BEATS)
            queue_random_burst();
         drain_block();
      end

      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (replies_due.size() != 0)
            $error("%0d expected result beats never arrived", replies_due.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/drfp_pkg.sv
hdl/drfp_frame_ram.sv
hdl/drfp_rx_front.sv
hdl/drfp_decode_seq.sv
hdl/display_reply_frame_parser.sv
dv/testbench.sv
